[hw/rtl/nbt_pkg.sv]
// Shared types and constants for the nearest box table.
// Depends on nothing; used by every module of the block and by its checker.
package nbt_pkg;

    localparam int unsigned NBT_MAX_BOXES  = 64;
    localparam int unsigned NBT_COORD_BITS = 12;
    localparam int unsigned NBT_IDX_W      = 10;  // enough for the largest table
    localparam logic [8:0]  NBT_CLASS_RST  = 9'd80;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_CLEAR  = 2'd1,
        REQ_CHANGE = 2'd2,
        REQ_REMOVE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_ROTATE,
        CMD_ADD,
        CMD_LABEL,
        CMD_REMOVE
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op              op;
        logic [NBT_IDX_W-1:0] idx;
    } t_cell_cmd;

endpackage

[hw/rtl/nearest_box_table.sv]
// Nearest box table. Add and clear, and change or remove on an empty table, go
// straight to the finish state, where their result is registered; change label and
// remove nearest first make one full rotation of the entry row and drain the
// distance pipeline before the result is registered. A stalled result holds the
// block; the next item is accepted the cycle after the result is registered.
// Reset (synchronous, active low) empties the table and sets the class count to 80.
module nearest_box_table #(
    parameter int unsigned MAX_BOXES  = nbt_pkg::NBT_MAX_BOXES,
    parameter int unsigned COORD_BITS = nbt_pkg::NBT_COORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [8:0]            i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_req_type,
    input  logic [COORD_BITS-1:0] i_coord_a,
    input  logic [COORD_BITS-1:0] i_coord_b,
    input  logic [COORD_BITS-1:0] i_coord_c,
    input  logic [COORD_BITS-1:0] i_coord_d,
    input  logic                  i_center_form,
    input  logic [7:0]            i_box_label,
    input  logic [COORD_BITS-1:0] i_point_x,
    input  logic [COORD_BITS-1:0] i_point_y,
    input  logic signed [8:0]     i_label_step,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_status,
    output logic [7:0]            o_new_label,
    output logic [6:0]            o_entry_count
);
    import nbt_pkg::*;

    // The table is a ring of cells. A search rotates the ring once, so each
    // entry in turn sits in cell 0 and is fed into the distance pipeline. After
    // a full turn every entry is back in its place and the winner is known by
    // index; the final update is then a single command on which each cell decides by
    // its own position. Only the top-left corner is stored: the far corner
    // never bears on a result.

    localparam int unsigned CW = $clog2(MAX_BOXES + 1);
    localparam int unsigned SCW = $clog2(MAX_BOXES + 2);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state                 r_state;
    logic [CW-1:0]          r_count;
    logic [SCW-1:0]         r_step;
    logic [8:0]             r_class;

    logic                   r_out_valid;
    logic [1:0]             r_status;
    logic [7:0]             r_new_label;
    logic [6:0]             r_out_count;

    // Latched item.
    t_req                   r_req;
    logic [COORD_BITS-1:0]  r_a, r_b, r_c, r_d, r_px, r_py;
    logic                   r_center;
    logic [7:0]             r_label;
    logic signed [8:0]      r_lstep;

    logic signed [COORD_BITS:0] cell_x [MAX_BOXES];
    logic signed [COORD_BITS:0] cell_y [MAX_BOXES];
    logic [7:0]                 cell_lab [MAX_BOXES];

    t_cell_cmd              cmd;
    logic signed [COORD_BITS:0] new_x, new_y;
    logic [7:0]             new_lab;

    logic [NBT_IDX_W-1:0]   best_idx;
    logic [7:0]             best_lab;
    logic                   scan_valid;
    logic                   rotating;

    logic                   out_free;
    logic                   in_fire;
    logic                   bad_box;
    logic                   full;
    logic signed [9:0]      label_sum;
    logic [7:0]             wrapped;

    logic [1:0]             n_status;
    logic [7:0]             n_new_label;
    logic [CW-1:0]          n_count;

    assign o_cfg_ready   = 1'b1;
    assign o_in_ready    = (r_state == S_IDLE);
    assign in_fire       = i_in_valid && o_in_ready;
    assign out_free      = !r_out_valid || i_out_ready;
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_new_label   = r_new_label;
    assign o_entry_count = r_out_count;

    assign rotating   = (r_state == S_SCAN) && (SCW'(r_step) < SCW'(MAX_BOXES));
    assign scan_valid = rotating && (SCW'(r_step) < SCW'(r_count));

    assign bad_box = (r_a == '0) || (r_b == '0) || (r_c == '0) || (r_d == '0);
    assign full    = (r_count == CW'(MAX_BOXES));

    // Label change with wrap: below zero goes to the top class, past it to zero.
    assign label_sum = signed'({2'b00, best_lab}) + 10'(r_lstep);
    always_comb begin
        if (label_sum[9]) begin
            wrapped = 8'(r_class - 9'd1);
        end else if (label_sum[8:0] >= r_class) begin
            wrapped = 8'd0;
        end else begin
            wrapped = label_sum[7:0];
        end
    end

    // Geometry of a new box: centre form subtracts half the size, corner
    // form takes the smaller of each pair.
    always_comb begin
        if (r_center) begin
            new_x = signed'({1'b0, r_a}) - signed'({2'b00, r_c[COORD_BITS-1:1]});
            new_y = signed'({1'b0, r_b}) - signed'({2'b00, r_d[COORD_BITS-1:1]});
        end else begin
            new_x = signed'({1'b0, (r_a < r_c) ? r_a : r_c});
            new_y = signed'({1'b0, (r_b < r_d) ? r_b : r_d});
        end
        new_lab = (r_req == REQ_ADD) ? r_label : wrapped;
    end

    always_comb begin
        cmd.op  = CMD_HOLD;
        cmd.idx = '0;
        if (rotating) begin
            cmd.op = CMD_ROTATE;
        end else if (r_state == S_FINISH && out_free) begin
            unique case (r_req)
                REQ_ADD: begin
                    if (!bad_box && !full) begin
                        cmd.op  = CMD_ADD;
                        cmd.idx = NBT_IDX_W'(r_count);
                    end
                end
                REQ_CHANGE: begin
                    if (r_count != '0) begin
                        cmd.op  = CMD_LABEL;
                        cmd.idx = best_idx;
                    end
                end
                REQ_REMOVE: begin
                    if (r_count != '0) begin
                        cmd.op  = CMD_REMOVE;
                        cmd.idx = best_idx;
                    end
                end
                default: ;
            endcase
        end
    end

    // Result of the item being finished and the entry count it leaves behind.
    always_comb begin
        n_status    = ST_OK;
        n_new_label = 8'd0;
        n_count     = r_count;
        unique case (r_req)
            REQ_ADD: begin
                if (bad_box) begin
                    n_status = ST_INVALID;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            REQ_CLEAR: begin
                n_count = '0;
            end
            REQ_CHANGE: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_new_label = wrapped;
                end
            end
            REQ_REMOVE: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            default: ;
        endcase
    end

    for (genvar k = 0; k < MAX_BOXES; k++) begin : g_cell
        nbt_cell #(
            .COORD_BITS(COORD_BITS),
            .POS       (k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_cmd    (cmd),
            .i_nb_x   (cell_x[(k + 1) % MAX_BOXES]),
            .i_nb_y   (cell_y[(k + 1) % MAX_BOXES]),
            .i_nb_lab (cell_lab[(k + 1) % MAX_BOXES]),
            .i_new_x  (new_x),
            .i_new_y  (new_y),
            .i_new_lab(new_lab),
            .o_x      (cell_x[k]),
            .o_y      (cell_y[k]),
            .o_lab    (cell_lab[k])
        );
    end

    nbt_dist #(
        .COORD_BITS(COORD_BITS)
    ) u_dist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (scan_valid),
        .i_idx     (NBT_IDX_W'(r_step)),
        .i_x       (cell_x[0]),
        .i_y       (cell_y[0]),
        .i_lab     (cell_lab[0]),
        .i_px      (r_px),
        .i_py      (r_py),
        .o_best_idx(best_idx),
        .o_best_lab(best_lab)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_class     <= NBT_CLASS_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_class <= i_cfg_data;
            end
            if (r_state == S_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_step <= '0;
                    if (in_fire) begin
                        if ((i_req_type == REQ_CHANGE || i_req_type == REQ_REMOVE)
                            && r_count != '0) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_SCAN: begin
                    r_step <= r_step + 1'b1;
                    // After the last rotation the state stays here until the pipeline has drained.
                    if (r_step == SCW'(MAX_BOXES + 1)) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_state     <= S_IDLE;
                        r_status    <= n_status;
                        r_new_label <= n_new_label;
                        r_count     <= n_count;
                        r_out_count <= 7'(n_count);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
        if (in_fire) begin
            r_req    <= t_req'(i_req_type);
            r_a      <= i_coord_a;
            r_b      <= i_coord_b;
            r_c      <= i_coord_c;
            r_d      <= i_coord_d;
            r_center <= i_center_form;
            r_label  <= i_box_label;
            r_px     <= i_point_x;
            r_py     <= i_point_y;
            r_lstep  <= i_label_step;
        end
    end

endmodule

[hw/rtl/nbt_cell.sv]
// One entry of the box table: top-left corner and label.
// Depends on nbt_pkg for the command struct broadcast to every entry.
module nbt_cell #(
    parameter int unsigned COORD_BITS = nbt_pkg::NBT_COORD_BITS,
    parameter int unsigned POS        = 0
) (
    input  logic                         i_clk,
    input  nbt_pkg::t_cell_cmd           i_cmd,
    input  logic signed [COORD_BITS:0]   i_nb_x,
    input  logic signed [COORD_BITS:0]   i_nb_y,
    input  logic [7:0]                   i_nb_lab,
    input  logic signed [COORD_BITS:0]   i_new_x,
    input  logic signed [COORD_BITS:0]   i_new_y,
    input  logic [7:0]                   i_new_lab,
    output logic signed [COORD_BITS:0]   o_x,
    output logic signed [COORD_BITS:0]   o_y,
    output logic [7:0]                   o_lab
);
    import nbt_pkg::*;

    logic hit;
    logic at_or_after;

    assign hit         = (i_cmd.idx == NBT_IDX_W'(POS));
    assign at_or_after = (NBT_IDX_W'(POS) >= i_cmd.idx);

    // Rotation and removal both take the neighbour's entry; removal only from
    // the removed position onwards, which keeps the order of the others.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            CMD_ROTATE: begin
                o_x   <= i_nb_x;
                o_y   <= i_nb_y;
                o_lab <= i_nb_lab;
            end
            CMD_REMOVE: begin
                if (at_or_after) begin
                    o_x   <= i_nb_x;
                    o_y   <= i_nb_y;
                    o_lab <= i_nb_lab;
                end
            end
            CMD_ADD: begin
                if (hit) begin
                    o_x   <= i_new_x;
                    o_y   <= i_new_y;
                    o_lab <= i_new_lab;
                end
            end
            CMD_LABEL: begin
                if (hit) begin
                    o_lab <= i_new_lab;
                end
            end
            default: ;
        endcase
    end

endmodule

[hw/rtl/nbt_dist.sv]
// Distance pipeline at the head of the entry row: squared distance and running minimum.
// Depends on nbt_pkg for the index width.
module nbt_dist #(
    parameter int unsigned COORD_BITS = nbt_pkg::NBT_COORD_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [nbt_pkg::NBT_IDX_W-1:0]       i_idx,
    input  logic signed [COORD_BITS:0]          i_x,
    input  logic signed [COORD_BITS:0]          i_y,
    input  logic [7:0]                          i_lab,
    input  logic [COORD_BITS-1:0]               i_px,
    input  logic [COORD_BITS-1:0]               i_py,
    output logic [nbt_pkg::NBT_IDX_W-1:0]       o_best_idx,
    output logic [7:0]                          o_best_lab
);
    import nbt_pkg::*;

    localparam int unsigned DW = COORD_BITS + 2;
    localparam int unsigned SW = 2 * DW;

    logic                     r_v1, r_v2;
    logic [NBT_IDX_W-1:0]     r_idx1, r_idx2;
    logic [7:0]               r_lab1, r_lab2;
    logic signed [DW-1:0]     r_dx, r_dy;
    logic signed [SW-1:0]     r_sx, r_sy;
    logic [SW:0]              r_best_d;
    logic [SW:0]              sq_sum;

    assign sq_sum = {1'b0, r_sx} + {1'b0, r_sy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_idx1 <= i_idx;
        r_lab1 <= i_lab;
        r_dx   <= DW'(i_x) - signed'({2'b00, i_px});
        r_dy   <= DW'(i_y) - signed'({2'b00, i_py});
        r_idx2 <= r_idx1;
        r_lab2 <= r_lab1;
        r_sx   <= r_dx * r_dx;
        r_sy   <= r_dy * r_dy;
        // The earliest entry wins a tie: only a strictly smaller distance replaces it.
        if (r_v2 && (r_idx2 == '0 || sq_sum < r_best_d)) begin
            r_best_d   <= sq_sum;
            o_best_idx <= r_idx2;
            o_best_lab <= r_lab2;
        end
    end

endmodule

[hw/rtl/nbt_checker.sv]
// Port-level checks for the nearest box table, bound to its top level.
// Depends on nbt_pkg for status codes and the default table size.
module nbt_checker #(
    parameter int unsigned MAX_BOXES = nbt_pkg::NBT_MAX_BOXES
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_status,
    input logic [7:0] o_new_label,
    input logic [6:0] o_entry_count
);
    import nbt_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_entry_count))
        else $error("result changed while stalled");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |-> o_entry_count == 7'(MAX_BOXES))
        else $error("full status with a table that is not full");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |-> o_entry_count == 7'd0
            && o_new_label == 8'd0)
        else $error("empty status with entries or a label");

    a_label: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_new_label != 8'd0 |-> o_status == ST_OK)
        else $error("label reported on a refused item");

endmodule

bind nearest_box_table nbt_checker #(.MAX_BOXES(MAX_BOXES)) u_nbt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_status     (o_status),
    .o_new_label  (o_new_label),
    .o_entry_count(o_entry_count)
);

[sim/nearest_box_table_tb.sv]
// Self-checking testbench for the nearest box table: drives requests, predicts results.
// Depends on nbt_pkg and the nearest_box_table RTL only.
module nearest_box_table_tb;
    import nbt_pkg::*;

    localparam int unsigned BOXES = NBT_MAX_BOXES;
    localparam int unsigned CW    = NBT_COORD_BITS;
    localparam int unsigned CYCLE_LIMIT = 2000000;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_cfg_valid = 1'b0;
    logic            o_cfg_ready;
    logic [8:0]      i_cfg_data = '0;
    logic            i_in_valid = 1'b0;
    logic            o_in_ready;
    logic [1:0]      i_req_type = '0;
    logic [CW-1:0]   i_coord_a = '0, i_coord_b = '0, i_coord_c = '0, i_coord_d = '0;
    logic            i_center_form = 1'b0;
    logic [7:0]      i_box_label = '0;
    logic [CW-1:0]   i_point_x = '0, i_point_y = '0;
    logic signed [8:0] i_label_step = '0;
    logic            o_out_valid;
    logic            i_out_ready = 1'b0;
    logic [1:0]      o_status;
    logic [7:0]      o_new_label;
    logic [6:0]      o_entry_count;

    nearest_box_table u_dut (.*);

    always #1 i_clk = ~i_clk;

    typedef struct packed {
        t_status    status;
        logic [7:0] new_label;
        logic [6:0] count;
    } t_answer;

    // The predictor's own copy of the table. Corners are kept as 32-bit signed ints,
    // which covers a centre-form corner going below zero.
    int         corner_x[BOXES];
    int         corner_y[BOXES];
    logic [7:0] labels[BOXES];
    int         held;
    int         classes;

    t_answer    answers_due[$];
    int         errors;
    int         cycles;
    int         send_idle_pct;
    int         take_stall_pct;

    // Work out the result of one request and update the copy of the table.
    function automatic t_answer predict_request(t_req req, int a, int b, int c, int d,
                                                bit centre, logic [7:0] lab, int px, int py,
                                                int step);
        t_answer ans;
        int best, best_d, sq_d, t;
        ans = '{ST_OK, 8'd0, 7'd0};
        case (req)
            REQ_ADD: begin
                if (a == 0 || b == 0 || c == 0 || d == 0) begin
                    ans.status = ST_INVALID;
                end else if (held >= BOXES) begin
                    ans.status = ST_FULL;
                end else begin
                    if (centre) begin
                        corner_x[held] = a - c / 2;
                        corner_y[held] = b - d / 2;
                    end else begin
                        corner_x[held] = (a < c) ? a : c;
                        corner_y[held] = (b < d) ? b : d;
                    end
                    labels[held] = lab;
                    held++;
                end
            end
            REQ_CLEAR: held = 0;
            default: begin
                if (held == 0) begin
                    ans.status = ST_EMPTY;
                end else begin
                    best = 0;
                    best_d = 0;
                    for (int i = 0; i < held; i++) begin
                        sq_d = (corner_x[i] - px) * (corner_x[i] - px)
                             + (corner_y[i] - py) * (corner_y[i] - py);
                        if (i == 0 || sq_d < best_d) begin
                            best = i;
                            best_d = sq_d;
                        end
                    end
                    if (req == REQ_CHANGE) begin
                        t = int'(labels[best]) + step;
                        if (t < 0) t = classes - 1;
                        else if (t >= classes) t = 0;
                        labels[best] = t[7:0];
                        ans.new_label = t[7:0];
                    end else begin
                        for (int i = best; i + 1 < held; i++) begin
                            corner_x[i] = corner_x[i + 1];
                            corner_y[i] = corner_y[i + 1];
                            labels[i] = labels[i + 1];
                        end
                        held--;
                    end
                end
            end
        endcase
        ans.count = held[6:0];
        return ans;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    // Sends one request, holding valid and payload until it is accepted. Valid
    // stays high after acceptance until an idle cycle or a drain lowers it, so
    // items can follow each other without a gap.
    task automatic send_request(t_req req, int a, int b, int c, int d, bit centre,
                                logic [7:0] lab, int px, int py, int step);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_type    <= req;
        i_coord_a     <= a[CW-1:0];
        i_coord_b     <= b[CW-1:0];
        i_coord_c     <= c[CW-1:0];
        i_coord_d     <= d[CW-1:0];
        i_center_form <= centre;
        i_box_label   <= lab;
        i_point_x     <= px[CW-1:0];
        i_point_y     <= py[CW-1:0];
        i_label_step  <= step[8:0];
        i_in_valid    <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        answers_due.push_back(predict_request(req, a, b, c, d, centre, lab, px, py, step));
    endtask

    // Waits for every outstanding result, then lets the block settle.
    task automatic drain;
        i_in_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (BOXES + 10) @(posedge i_clk);
    endtask

    // Writes the class count; only called with nothing outstanding.
    task automatic write_classes(int value);
        i_cfg_data  <= value[8:0];
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        classes = value;
    endtask

    // Random request: mostly adds and searches, with clears rare so the table fills.
    task automatic send_random_request;
        int r;
        t_req req;
        r = $urandom_range(99);
        if (r < 45) req = REQ_ADD;
        else if (r < 47) req = REQ_CLEAR;
        else if (r < 75) req = REQ_CHANGE;
        else req = REQ_REMOVE;
        send_request(req,
            ($urandom_range(19) == 0) ? 0 : $urandom_range(4095),
            ($urandom_range(19) == 0) ? 0 : $urandom_range(4095),
            ($urandom_range(19) == 0) ? 0 : $urandom_range(4095),
            ($urandom_range(19) == 0) ? 0 : $urandom_range(4095),
            1'($urandom_range(1)), 8'($urandom_range(255)), $urandom_range(4095),
            $urandom_range(4095), int'($urandom_range(510)) - 255);
    endtask

    // Results are taken here with random back-pressure and checked in order.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (answers_due.size() == 0) begin
                $display("result arrived with nothing expected");
                errors++;
            end else begin
                want = answers_due.pop_front();
                if (o_status != want.status) report_mismatch("status", o_status, want.status);
                if (o_new_label != want.new_label)
                    report_mismatch("new_label", o_new_label, want.new_label);
                if (o_entry_count != want.count)
                    report_mismatch("entry_count", o_entry_count, want.count);
            end
        end
        i_out_ready <= ($urandom_range(99) >= take_stall_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Edge cases: invalid coordinates, empty searches, label wraps, ties, full table.
    task automatic test_directed;
        send_request(REQ_CHANGE, 1, 1, 1, 1, 0, 0, 0, 0, 5);
        send_request(REQ_REMOVE, 1, 1, 1, 1, 0, 0, 4095, 4095, 0);
        send_request(REQ_ADD, 0, 5, 5, 5, 0, 1, 0, 0, 0);
        send_request(REQ_ADD, 5, 5, 5, 0, 1, 1, 0, 0, 0);
        send_request(REQ_ADD, 4095, 4095, 1, 1, 0, 255, 0, 0, 0);
        send_request(REQ_ADD, 1, 1, 4095, 4095, 1, 0, 0, 0, 0);
        send_request(REQ_ADD, 4095, 4095, 4095, 4095, 1, 79, 0, 0, 0);
        // Two boxes with the same corner: the earlier one must win the tie.
        send_request(REQ_ADD, 10, 10, 20, 20, 0, 3, 0, 0, 0);
        send_request(REQ_ADD, 20, 20, 10, 10, 0, 4, 0, 0, 0);
        send_request(REQ_CHANGE, 0, 0, 0, 0, 0, 0, 10, 10, 255);
        send_request(REQ_CHANGE, 0, 0, 0, 0, 0, 0, 10, 10, -255);
        send_request(REQ_CHANGE, 0, 0, 0, 0, 0, 0, 0, 0, -1);
        send_request(REQ_CHANGE, 0, 0, 0, 0, 0, 0, 4095, 4095, 1);
        send_request(REQ_REMOVE, 0, 0, 0, 0, 0, 0, 10, 10, 0);
        send_request(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < BOXES + 2; i++)
            send_request(REQ_ADD, i + 1, 4000 - i, 7, 9, i[0], i[7:0], 0, 0, 0);
        send_request(REQ_REMOVE, 0, 0, 0, 0, 0, 0, 2048, 2048, 0);
        drain();
    endtask

    // One random phase under the given idling pattern.
    task automatic test_random_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        take_stall_pct = stall;
        repeat (n) send_random_request();
        drain();
        send_idle_pct = 0;
        take_stall_pct = 0;
    endtask

    // Label wrap under extreme and mid class counts.
    task automatic test_class_counts;
        write_classes(1);
        test_random_phase(150, 0, 0);
        write_classes(256);
        test_random_phase(150, 30, 30);
        write_classes(0);
        test_random_phase(100, 0, 0);
        write_classes(511);
        test_random_phase(100, 0, 0);
        write_classes(17);
        test_random_phase(150, 0, 66);
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        held = 0;
        classes = int'(NBT_CLASS_RST);
        send_idle_pct = 0;
        take_stall_pct = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phase(300, 0, 0);
        test_random_phase(300, 66, 0);
        test_random_phase(300, 0, 66);
        test_random_phase(300, 30, 30);
        test_class_counts();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
